// ===== rtl/isl_pkg.sv =====
// Package for the interpolation segment locator.
// Holds the channel payload structs, codes, FSM states and controller links.
// No dependencies.
package isl_pkg;

    // Input transaction payload
    typedef struct packed {
        logic               opcode;
        logic [5:0]         point_index;
        logic signed [31:0] time_value;
        logic [47:0]        query_time;
    } in_item_t;

    // Result transaction payload
    typedef struct packed {
        logic [2:0]  status_code;
        logic        hit_valid;
        logic [5:0]  segment_index;
        logic [16:0] scale_q16;
    } out_item_t;

    // Opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TIME  = 4'd1;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FEW      = 3'd1;
    localparam logic [2:0] ST_BEFORE   = 3'd2;
    localparam logic [2:0] ST_AFTER    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // Fixed-point constants
    localparam logic [16:0] Q16_HALF = 17'd32768;
    localparam logic [16:0] Q16_ONE  = 17'd65536;
    localparam logic [4:0]  DIV_LAST = 5'd16;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD0,
        S_FIRST,
        S_LAST,
        S_WALK,
        S_DIV,
        S_DONE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic       load;
        logic       query;
        logic       rd_first;
        logic       rd_last;
        logic       walk_start;
        logic       walk_step;
        logic       div_start;
        logic       div_step;
        logic       set_status;
        logic [2:0] status_code;
        logic       res_load;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic few;
        logic before_first;
        logic after;
        logic hit;
        logic zero_step;
        logic walk_end;
        logic div_last;
    } sts_t;

endpackage

// ===== rtl/interpolation_segment_locator_top.sv =====
// Top level of the interpolation segment locator.
// Joins isl_ctrl and isl_datapath; depends on isl_pkg.
//
//  Channel  Signals                           Direction  Moves
//  in       in_valid/in_ready/in_data         sink       load or query transaction
//  out      out_valid/out_ready/out_data      source     one result per query
//  cfg      cfg_valid/cfg_ready/cfg_index/    sink       register write
//           cfg_data
//
// A load is written from the idle state. A query with fewer than two points goes
// straight to the done state; one out of range ends after the first or last knot
// compare; a hit walks the segments one knot per cycle over the single table read
// port and then runs the 17-step restoring divider (a zero-length segment skips it).
// Reset clears control state and config registers; the knot table is not cleared.
// A result waits in the output register; a stalled output holds the FSM in its
// final state, and config writes are taken in every cycle.
module interpolation_segment_locator_top
#(
    parameter int MAX_POINTS = 64
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  isl_pkg::in_item_t                in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output isl_pkg::out_item_t               out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [isl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [47:0]                      cfg_data
);

    isl_pkg::cmd_t cmd;
    isl_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    isl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_opcode (in_data.opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    isl_datapath
    #(
        .MAX_POINTS (MAX_POINTS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

    // Never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!out_valid || out_ready))
        else $error("result register overwritten while pending");

    // A query blocks the input until its result is produced
    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.opcode == isl_pkg::OP_QUERY) |=> !in_ready)
        else $error("input accepted during a query");

    // Hit flag tracks an ok status
    a_hit_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.hit_valid == (out_data.status_code == isl_pkg::ST_OK)))
        else $error("hit_valid disagrees with status");

    // Failed queries carry zero index and fraction; fraction stays in range
    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.scale_q16 <= isl_pkg::Q16_ONE) &&
            (out_data.hit_valid ||
             (out_data.segment_index == 6'd0 && out_data.scale_q16 == 17'd0))))
        else $error("result fields out of range");

endmodule

// ===== rtl/isl_ctrl.sv =====
// Controller FSM for the interpolation segment locator.
// Sequences table reads, the segment walk and the divider; owns the handshakes.
// Depends on isl_pkg.
module isl_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           in_opcode,
    output logic           out_valid,
    input  logic           out_ready,
    input  isl_pkg::sts_t  sts,
    output isl_pkg::cmd_t  cmd
);

    isl_pkg::state_t state_reg;
    isl_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            isl_pkg::S_IDLE:
            begin
                if (in_valid && in_opcode == isl_pkg::OP_QUERY)
                begin
                    state_next = sts.few ? isl_pkg::S_DONE : isl_pkg::S_RD0;
                end
            end
            isl_pkg::S_RD0:
            begin
                state_next = isl_pkg::S_FIRST;
            end
            isl_pkg::S_FIRST:
            begin
                state_next = sts.before_first ? isl_pkg::S_DONE : isl_pkg::S_LAST;
            end
            isl_pkg::S_LAST:
            begin
                state_next = sts.after ? isl_pkg::S_DONE : isl_pkg::S_WALK;
            end
            isl_pkg::S_WALK:
            begin
                if (sts.hit)
                begin
                    state_next = sts.zero_step ? isl_pkg::S_DONE : isl_pkg::S_DIV;
                end
                else if (sts.walk_end)
                begin
                    state_next = isl_pkg::S_DONE;
                end
            end
            isl_pkg::S_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = isl_pkg::S_DONE;
                end
            end
            isl_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = isl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = isl_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            isl_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_opcode == isl_pkg::OP_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else
                    begin
                        cmd.query = 1'b1;
                        if (sts.few)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = isl_pkg::ST_FEW;
                        end
                    end
                end
            end
            isl_pkg::S_RD0:
            begin
                cmd.rd_first = 1'b1;
            end
            isl_pkg::S_FIRST:
            begin
                if (sts.before_first)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = isl_pkg::ST_BEFORE;
                end
                else
                begin
                    cmd.rd_last = 1'b1;
                end
            end
            isl_pkg::S_LAST:
            begin
                if (sts.after)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = isl_pkg::ST_AFTER;
                end
                else
                begin
                    cmd.walk_start = 1'b1;
                end
            end
            isl_pkg::S_WALK:
            begin
                if (sts.hit)
                begin
                    cmd.div_start = 1'b1;
                    if (sts.zero_step)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = isl_pkg::ST_OK;
                    end
                end
                else if (sts.walk_end)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = isl_pkg::ST_NOTFOUND;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            isl_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = isl_pkg::ST_OK;
                end
            end
            isl_pkg::S_DONE:
            begin
                cmd.res_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Hold a result until the output transaction completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= isl_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/isl_datapath.sv =====
// Datapath for the interpolation segment locator.
// Knot table memory, config registers, range compares, segment walk, divider.
// Depends on isl_pkg.
module isl_datapath
#(
    parameter int MAX_POINTS = 64
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  isl_pkg::cmd_t                    cmd,
    output isl_pkg::sts_t                    sts,
    input  isl_pkg::in_item_t                in_data,
    input  logic                             cfg_valid,
    input  logic [isl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [47:0]                      cfg_data,
    output isl_pkg::out_item_t               out_data
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int CW = NW + 1;

    // Knot table and registered read port
    logic [31:0]        knot_mem [MAX_POINTS];
    logic [31:0]        rd_data_reg;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;

    // Config registers
    logic [6:0]         point_count_reg;
    logic [47:0]        start_time_reg;

    // Query registers
    logic signed [48:0] t_reg;
    logic [31:0]        prev_reg;
    logic [AW-1:0]      seg_reg;
    logic [2:0]         status_reg;

    // Divider registers
    logic [33:0]        div_rem_reg;
    logic [33:0]        div_rem_next;
    logic [31:0]        div_den_reg;
    logic [16:0]        div_q_reg;
    logic [16:0]        div_q_next;
    logic [4:0]         div_cnt_reg;

    logic [NW-1:0]      n_eff;
    logic signed [48:0] cur_ext;
    logic signed [48:0] prev_ext;
    logic signed [48:0] t_calc;
    logic [CW-1:0]      seg_plus2;
    logic               div_ge;
    logic [33:0]        div_sub;
    logic               is_ok;

    // Clamp point count to the table depth
    always_comb
    begin
        if (int'(point_count_reg) > MAX_POINTS)
        begin
            n_eff = NW'(MAX_POINTS);
        end
        else
        begin
            n_eff = NW'(point_count_reg);
        end
    end

    assign cur_ext   = 49'(signed'(rd_data_reg));
    assign prev_ext  = 49'(signed'(prev_reg));
    assign t_calc    = $signed({1'b0, in_data.query_time}) - $signed({1'b0, start_time_reg});
    assign seg_plus2 = CW'(seg_reg) + CW'(2);

    // Status to controller
    always_comb
    begin
        sts              = '0;
        sts.few          = n_eff < NW'(2);
        sts.before_first = t_reg < cur_ext;
        sts.after        = t_reg > cur_ext;
        sts.hit          = (prev_ext <= t_reg) && (t_reg <= cur_ext);
        sts.zero_step    = rd_data_reg == prev_reg;
        sts.walk_end     = seg_plus2 >= CW'(n_eff);
        sts.div_last     = div_cnt_reg == isl_pkg::DIV_LAST;
    end

    // Select the table read address
    assign rd_en = cmd.rd_first || cmd.rd_last || cmd.walk_start || cmd.walk_step;
    always_comb
    begin
        if (cmd.rd_last)
        begin
            rd_addr = AW'(n_eff - NW'(1));
        end
        else if (cmd.walk_start)
        begin
            rd_addr = AW'(1);
        end
        else if (cmd.walk_step)
        begin
            rd_addr = AW'(seg_plus2);
        end
        else
        begin
            rd_addr = '0;
        end
    end

    // Drop loads to slots beyond the table
    assign wr_en = cmd.load && (int'(in_data.point_index) < MAX_POINTS);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            knot_mem[AW'(in_data.point_index)] <= in_data.time_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= knot_mem[rd_addr];
        end
    end

    // Config register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
            start_time_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == isl_pkg::CFG_POINT_COUNT)
            begin
                point_count_reg <= cfg_data[6:0];
            end
            else if (cfg_index == isl_pkg::CFG_START_TIME)
            begin
                start_time_reg <= cfg_data;
            end
        end
    end

    // One restoring division step per cycle
    assign div_ge       = div_rem_reg >= {2'b00, div_den_reg};
    assign div_sub      = div_ge ? (div_rem_reg - {2'b00, div_den_reg}) : div_rem_reg;
    assign div_rem_next = {div_sub[32:0], 1'b0};
    assign div_q_next   = {div_q_reg[15:0], div_ge};

    // Query, walk and divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.query)
        begin
            t_reg <= t_calc;
        end
        if (cmd.rd_last)
        begin
            prev_reg <= rd_data_reg;
        end
        if (cmd.walk_start)
        begin
            seg_reg <= '0;
        end
        if (cmd.walk_step)
        begin
            prev_reg <= rd_data_reg;
            seg_reg  <= seg_reg + AW'(1);
        end
        if (cmd.div_start)
        begin
            div_den_reg <= 32'(rd_data_reg - prev_reg);
            div_rem_reg <= {2'b00, 32'(t_reg - prev_ext)};
            div_cnt_reg <= '0;
            div_q_reg   <= sts.zero_step ? isl_pkg::Q16_HALF : '0;
        end
        if (cmd.div_step)
        begin
            div_rem_reg <= div_rem_next;
            div_q_reg   <= div_q_next;
            div_cnt_reg <= div_cnt_reg + 5'd1;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status_code;
        end
    end

    // Result register; failed queries carry zero index and fraction
    assign is_ok = status_reg == isl_pkg::ST_OK;

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_data.status_code   <= status_reg;
            out_data.hit_valid     <= is_ok;
            out_data.segment_index <= is_ok ? 6'(seg_reg) : 6'd0;
            out_data.scale_q16     <= is_ok ? div_q_reg : 17'd0;
        end
    end

endmodule
